@@ design/decimating_highpass_audio_queue_core_defines.svh @@
// assertion macros used by the checker of the audio queue core
`ifndef DECIMATING_HIGHPASS_AUDIO_QUEUE_CORE_DEFINES_SVH
`define DECIMATING_HIGHPASS_AUDIO_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define DHAQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dhaq check failed");

// next-cycle implication, held off while reset is asserted
`define DHAQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dhaq check failed");

`endif

@@ design/dhaq_pkg.sv @@
package dhaq_pkg;

  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned SampleBits = 24;
  localparam int unsigned MaxDrain   = 64;
  localparam int unsigned CountW     = 7;
  localparam int unsigned TimeBits   = 64;
  localparam int unsigned PeriodBits = 20;
  localparam int unsigned CoefBits   = 15;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned CfgIdxW    = 2;

  typedef logic [CfgIdxW-1:0]           cfg_idx_t;
  typedef logic [CfgDataW-1:0]          cfg_data_t;
  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [TimeBits-1:0]          time_t;

  // register indexes
  localparam cfg_idx_t CfgEnable = 2'd0;
  localparam cfg_idx_t CfgPeriod = 2'd1;
  localparam cfg_idx_t CfgCoeff  = 2'd2;
  localparam cfg_idx_t CfgWeight = 2'd3;

  // command codes
  localparam logic CmdSubStep = 1'b0;
  localparam logic CmdDrain   = 1'b1;

  // register reset values
  localparam logic [PeriodBits-1:0] DefPeriod = 20'd20833;
  localparam logic [CoefBits-1:0]   DefCoeff  = 15'd32598;
  localparam logic [CoefBits-1:0]   DefWeight = 15'd655;

  typedef struct packed {
    logic              command;
    sample_t           torque_in;
    sample_t           current_in;
    time_t             now_ns;
    logic [CountW-1:0] max_count;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    time_t   sample_time;
    logic    valid_res;
    logic    last;
  } out_item_t;

endpackage

@@ design/dhaq_in_if.sv @@
interface dhaq_in_if;
  import dhaq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/dhaq_out_if.sv @@
interface dhaq_out_if;
  import dhaq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/decimating_highpass_audio_queue_core.sv @@
// sub-step without emit: SAcc, then ready again in SIdle; no item overlaps another
// sub-step with emit: ready again after the work of the bit-serial
// divider (32 steps per channel) and the single shared multiplier used three times
// drain: first result valid after SDrStart, SDrIssue and SDrLoad (SDrStart alone for an
// empty drain), then each further one after SDrIssue and SDrLoad and any output stall
// reset (rst_ni low, asynchronous) clears control, sums, filters and ring pointers, not the ring
module decimating_highpass_audio_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  dhaq_in_if.sink             in_i,
  dhaq_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  dhaq_pkg::cfg_idx_t  cfg_idx_i,
  input  dhaq_pkg::cfg_data_t cfg_wdata_i
);
  import dhaq_pkg::*;

  // accumulator and datapath widths
  localparam int unsigned SumBits  = 32;
  localparam int unsigned CntBits  = 8;
  localparam int unsigned StepW    = $clog2(SumBits);
  localparam int unsigned FiltBits = SampleBits + 2;
  localparam int unsigned ProdBits = FiltBits + CoefBits;
  localparam int unsigned RndW     = ProdBits + 1 - CoefBits;
  localparam int unsigned SatW     = SumBits + 2;
  localparam int unsigned EntryW   = SampleBits + TimeBits;

  localparam logic [CntBits-1:0]      CntFull   = {CntBits{1'b1}};
  localparam logic [StepW-1:0]        LastStep  = StepW'(SumBits - 1);
  localparam logic [CountW-1:0]       DrainCap  = CountW'(MaxDrain);
  localparam logic [ProdBits:0]       RoundHalf =
    {{(ProdBits + 1 - CoefBits){1'b0}}, 1'b1, {(CoefBits - 1){1'b0}}};
  localparam logic signed [SatW-1:0]  SatMax =
    {{(SatW - SampleBits + 1){1'b0}}, {(SampleBits - 1){1'b1}}};
  localparam logic signed [SatW-1:0]  SatMin =
    {{(SatW - SampleBits + 1){1'b1}}, {(SampleBits - 1){1'b0}}};
  localparam logic signed [SumBits-1:0] Sum32Max = {1'b0, {(SumBits - 1){1'b1}}};
  localparam logic signed [SumBits-1:0] Sum32Min = {1'b1, {(SumBits - 1){1'b0}}};

  // sequencer states
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SAcc     = 4'd1;
  localparam logic [3:0] SDivLoad = 4'd2;
  localparam logic [3:0] SDivStep = 4'd3;
  localparam logic [3:0] SDivFin  = 4'd4;
  localparam logic [3:0] SFiltSum = 4'd5;
  localparam logic [3:0] SMul     = 4'd6;
  localparam logic [3:0] SFiltFin = 4'd7;
  localparam logic [3:0] SMixSum  = 4'd8;
  localparam logic [3:0] SMixFin  = 4'd9;
  localparam logic [3:0] SDrStart = 4'd10;
  localparam logic [3:0] SDrIssue = 4'd11;
  localparam logic [3:0] SDrLoad  = 4'd12;
  localparam logic [3:0] SOutWait = 4'd13;

  function automatic sample_t sat_sample(input logic signed [SatW-1:0] v);
    sample_t r;
    if (v > SatMax) r = SatMax[SampleBits-1:0];
    else if (v < SatMin) r = SatMin[SampleBits-1:0];
    else r = v[SampleBits-1:0];
    return r;
  endfunction

  function automatic logic signed [SumBits-1:0] sat_add32(
    input logic signed [SumBits-1:0] a, input sample_t b);
    logic signed [SumBits:0] s;
    s = {a[SumBits-1], a} + {{(SumBits + 1 - SampleBits){b[SampleBits-1]}}, b};
    if (s[SumBits] != s[SumBits-1]) return s[SumBits] ? Sum32Min : Sum32Max;
    return s[SumBits-1:0];
  endfunction

  // control state
  logic [3:0]                   state_q;
  logic                         en_q;
  logic [PeriodBits-1:0]        period_q;
  logic [CoefBits-1:0]          coef_q;
  logic [CoefBits-1:0]          weight_q;
  logic signed [SumBits-1:0]    sum_q [2];
  logic [CntBits-1:0]           cnt_q;
  sample_t                      yprev_q [2];
  sample_t                      xprev_q [2];
  time_t                        next_emit_q;
  logic [QueueAw-1:0]           rp_q;
  logic [QueueAw:0]             fill_q;
  logic                         ch_q;
  logic                         mix_q;
  logic [CountW-1:0]            left_q;
  logic                         out_valid_q;

  // datapath registers
  in_item_t                     item_q;
  logic [StepW-1:0]             step_q;
  logic [SumBits-1:0]           quo_q;
  logic [CntBits-1:0]           rem_q;
  logic                         neg_q;
  logic [FiltBits-1:0]          mag_q;
  logic [ProdBits-1:0]          mul_q;
  sample_t                      avg_q [2];
  logic [EntryW-1:0]            rd_q;
  out_item_t                    out_q;

  // sample ring
  logic [EntryW-1:0]            queue_mem [QueueDepth];

  // combinational helpers
  logic                         in_xfer;
  logic                         queue_full;
  logic [QueueAw-1:0]           wr_addr;
  logic [CntBits:0]             trial;
  logic                         trial_ge;
  logic [CntBits:0]             trial_diff;
  logic signed [SumBits-1:0]    sum_sel;
  logic [SumBits-1:0]           sum_mag;
  logic signed [SatW-1:0]       quo_signed;
  logic signed [FiltBits-1:0]   filt_sum;
  logic signed [FiltBits-1:0]   y1_ext;
  logic [ProdBits:0]            rnd_sum;
  logic [RndW-1:0]              rnd_mag;
  logic signed [RndW:0]         rnd_val;
  sample_t                      filt_y;
  sample_t                      mix_y;
  logic [CountW-1:0]            want;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == SIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // a full ring overwrites its oldest entry, which sits at the read pointer
  assign queue_full = (fill_q == (QueueAw + 1)'(QueueDepth));
  assign wr_addr    = queue_full ? rp_q : QueueAw'(rp_q + fill_q[QueueAw-1:0]);

  // one restoring division step, magnitude only
  assign trial      = {rem_q, quo_q[SumBits-1]};
  assign trial_ge   = (trial >= {1'b0, cnt_q});
  assign trial_diff = trial - {1'b0, cnt_q};

  assign sum_sel    = sum_q[ch_q];
  assign sum_mag    = sum_sel[SumBits-1] ? SumBits'(-sum_sel) : sum_sel;
  assign quo_signed = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  // filter input difference y_prev + x - x_prev
  assign filt_sum = {{2{yprev_q[ch_q][SampleBits-1]}}, yprev_q[ch_q]}
                  + {{2{avg_q[ch_q][SampleBits-1]}}, avg_q[ch_q]}
                  - {{2{xprev_q[ch_q][SampleBits-1]}}, xprev_q[ch_q]};
  assign y1_ext   = {{2{yprev_q[1][SampleBits-1]}}, yprev_q[1]};

  // round magnitude to nearest, ties away from zero, then restore the sign
  assign rnd_sum = {1'b0, mul_q} + RoundHalf;
  assign rnd_mag = rnd_sum[ProdBits:CoefBits];
  assign rnd_val = neg_q ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

  assign filt_y = sat_sample({{(SatW - RndW - 1){rnd_val[RndW]}}, rnd_val});
  assign mix_y  = sat_sample({{(SatW - SampleBits){yprev_q[0][SampleBits-1]}}, yprev_q[0]}
                           + {{(SatW - RndW - 1){rnd_val[RndW]}}, rnd_val});

  assign want = (item_q.max_count > DrainCap) ? DrainCap : item_q.max_count;

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      en_q        <= 1'b0;
      period_q    <= DefPeriod;
      coef_q      <= DefCoeff;
      weight_q    <= DefWeight;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      cnt_q       <= '0;
      yprev_q[0]  <= '0;
      yprev_q[1]  <= '0;
      xprev_q[0]  <= '0;
      xprev_q[1]  <= '0;
      next_emit_q <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      ch_q        <= 1'b0;
      mix_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_xfer) begin
            unique case (in_i.data.command)
              CmdSubStep: state_q <= SAcc;
              CmdDrain:   state_q <= SDrStart;
            endcase
          end
        end
        SAcc: begin
          // disabled: the sub-step is dropped
          if (!en_q) begin
            state_q <= SIdle;
          end else begin
            if (cnt_q != CntFull) begin
              sum_q[0] <= sat_add32(sum_q[0], item_q.torque_in);
              sum_q[1] <= sat_add32(sum_q[1], item_q.current_in);
              cnt_q    <= cnt_q + 1'b1;
            end
            if (item_q.now_ns >= next_emit_q) begin
              next_emit_q <= item_q.now_ns + TimeBits'(period_q);
              ch_q        <= 1'b0;
              state_q     <= SDivLoad;
            end else begin
              state_q <= SIdle;
            end
          end
        end
        SDivLoad: state_q <= SDivStep;
        SDivStep: begin
          if (step_q == LastStep) state_q <= SDivFin;
        end
        SDivFin: begin
          ch_q    <= ~ch_q;
          state_q <= ch_q ? SFiltSum : SDivLoad;
        end
        SFiltSum: begin
          mix_q   <= 1'b0;
          state_q <= SMul;
        end
        SMul: state_q <= mix_q ? SMixFin : SFiltFin;
        SFiltFin: begin
          yprev_q[ch_q] <= filt_y;
          xprev_q[ch_q] <= avg_q[ch_q];
          ch_q          <= ~ch_q;
          state_q       <= ch_q ? SMixSum : SFiltSum;
        end
        SMixSum: begin
          mix_q   <= 1'b1;
          state_q <= SMul;
        end
        SMixFin: begin
          // push; a full ring drops its oldest entry
          if (queue_full) rp_q <= rp_q + 1'b1;
          else fill_q <= fill_q + 1'b1;
          sum_q[0] <= '0;
          sum_q[1] <= '0;
          cnt_q    <= '0;
          state_q  <= SIdle;
        end
        SDrStart: begin
          if ((want == '0) || (fill_q == '0)) begin
            out_valid_q <= 1'b1;
            state_q     <= SOutWait;
          end else begin
            left_q  <= want;
            state_q <= SDrIssue;
          end
        end
        SDrIssue: begin
          rp_q    <= rp_q + 1'b1;
          fill_q  <= fill_q - 1'b1;
          left_q  <= left_q - 1'b1;
          state_q <= SDrLoad;
        end
        SDrLoad: begin
          out_valid_q <= 1'b1;
          state_q     <= SOutWait;
        end
        SOutWait: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= out_q.last ? SIdle : SDrIssue;
          end
        end
        default: state_q <= SIdle;
      endcase

      // the user must write registers only while the block is idle; the block does not enforce it
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgEnable: begin
            if (cfg_wdata_i[0] != en_q) begin
              en_q        <= cfg_wdata_i[0];
              sum_q[0]    <= '0;
              sum_q[1]    <= '0;
              cnt_q       <= '0;
              yprev_q[0]  <= '0;
              yprev_q[1]  <= '0;
              xprev_q[0]  <= '0;
              xprev_q[1]  <= '0;
              next_emit_q <= '0;
              rp_q        <= '0;
              fill_q      <= '0;
            end
          end
          CfgPeriod: period_q <= cfg_wdata_i[PeriodBits-1:0];
          CfgCoeff:  coef_q   <= cfg_wdata_i[CoefBits-1:0];
          CfgWeight: weight_q <= cfg_wdata_i[CoefBits-1:0];
        endcase
      end
    end
  end

  // shared divider, multiplier and output payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: begin
        if (in_xfer) item_q <= in_i.data;
      end
      SDivLoad: begin
        quo_q  <= sum_mag;
        neg_q  <= sum_sel[SumBits-1];
        rem_q  <= '0;
        step_q <= '0;
      end
      SDivStep: begin
        rem_q  <= trial_ge ? trial_diff[CntBits-1:0] : trial[CntBits-1:0];
        quo_q  <= {quo_q[SumBits-2:0], trial_ge};
        step_q <= step_q + 1'b1;
      end
      SDivFin: avg_q[ch_q] <= sat_sample(quo_signed);
      SFiltSum: begin
        neg_q <= filt_sum[FiltBits-1];
        mag_q <= filt_sum[FiltBits-1] ? FiltBits'(-filt_sum) : filt_sum;
      end
      SMixSum: begin
        neg_q <= y1_ext[FiltBits-1];
        mag_q <= y1_ext[FiltBits-1] ? FiltBits'(-y1_ext) : y1_ext;
      end
      SMul: mul_q <= ProdBits'(mag_q) * ProdBits'(mix_q ? weight_q : coef_q);
      SDrStart: begin
        out_q.sample_out  <= '0;
        out_q.sample_time <= '0;
        out_q.valid_res   <= 1'b0;
        out_q.last        <= 1'b1;
      end
      SDrLoad: begin
        out_q.sample_out  <= rd_q[EntryW-1:TimeBits];
        out_q.sample_time <= rd_q[TimeBits-1:0];
        out_q.valid_res   <= 1'b1;
        out_q.last        <= (left_q == '0) || (fill_q == '0);
      end
      default: ;
    endcase
  end

  // ring storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == SMixFin) queue_mem[wr_addr] <= {mix_y, item_q.now_ns};
    if (state_q == SDrIssue) rd_q <= queue_mem[rp_q];
  end

endmodule

@@ design/dhaq_checker.sv @@
`include "decimating_highpass_audio_queue_core_defines.svh"

module dhaq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dhaq_pkg::out_item_t out_data_i
);
  import dhaq_pkg::*;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // no new item is taken while a result waits
  `DHAQ_ASSERT_IMP(a_busy_while_out, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // an accepted item leaves the block busy in the next cycle
  `DHAQ_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_xfer, !in_ready_i)

  // an empty result is always the last one and carries zeros
  `DHAQ_ASSERT_IMP(a_empty_result, clk_i, rst_ni, out_valid_i && !out_data_i.valid_res,
    out_data_i.last && (out_data_i.sample_out == '0) && (out_data_i.sample_time == '0))

  // the final result of a drain is not followed straight away by another
  `DHAQ_ASSERT_NXT(a_gap_after_last, clk_i, rst_ni, out_xfer && out_data_i.last,
    !out_valid_i)

  // a stalled result holds
  `DHAQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_data_i))

endmodule

bind decimating_highpass_audio_queue_core dhaq_checker u_dhaq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
